/* src/tbasis_pkg.sv */
// shared helper functions for the triangle tangent basis block
`default_nettype none
package tbasis_pkg;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// right shift applied to texture deltas so that products stay within 64 bits
	function automatic int tex_shift(input int tex_w);
		return (tex_w > 30) ? tex_w - 30 : 0;
	endfunction

	// right shift applied to edge vectors so that products stay within 64 bits
	function automatic int pos_shift(input int pos_w, input int tex_w);
		int ts;
		ts = tex_shift(tex_w);
		return (pos_w + tex_w - ts > 60) ? pos_w + tex_w - ts - 60 : 0;
	endfunction

endpackage
`default_nettype wire

/* src/triangle_tangent_basis.sv */
// top level of the face tangent basis block: front end, request queue, back end
//
// channel   direction  handshake            payload
// vertex    in         in_valid / in_stall   mesh_start, pos_x/y/z, tex_u/v
// face      out        out_valid / out_stall tangent, binormal, normal xyz, degenerate
//
// first and second corners are taken without a stall and only held
// a third corner becomes a request in a two entry queue; it stalls only when the queue is full
// the back end takes one request at a time; its work per face is mostly the
// bit-serial divider (32 + OUT_WIDTH - 1 steps per component) and the 32 step square root
// reset clears corner count, queue and sequencer; held corners are not cleared
// a finished face sits in the output register while the next request is being worked on
`default_nettype none
module triangle_tangent_basis import tbasis_pkg::*; #(
	parameter int POS_WIDTH = 24,
	parameter int TEX_WIDTH = 21,
	parameter int OUT_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        mesh_start,
	input  wire logic signed [POS_WIDTH-1:0] pos_x,
	input  wire logic signed [POS_WIDTH-1:0] pos_y,
	input  wire logic signed [POS_WIDTH-1:0] pos_z,
	input  wire logic signed [TEX_WIDTH-1:0] tex_u,
	input  wire logic signed [TEX_WIDTH-1:0] tex_v,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed      [OUT_WIDTH-1:0] tangent_x,
	output logic signed      [OUT_WIDTH-1:0] tangent_y,
	output logic signed      [OUT_WIDTH-1:0] tangent_z,
	output logic signed      [OUT_WIDTH-1:0] binormal_x,
	output logic signed      [OUT_WIDTH-1:0] binormal_y,
	output logic signed      [OUT_WIDTH-1:0] binormal_z,
	output logic signed      [OUT_WIDTH-1:0] normal_x,
	output logic signed      [OUT_WIDTH-1:0] normal_y,
	output logic signed      [OUT_WIDTH-1:0] normal_z,
	output logic                             degenerate
);

	// request width: edge vectors e1, e2 and texture deltas du1, dv1, du2, dv2
	localparam int TS = tex_shift(TEX_WIDTH);
	localparam int PS = pos_shift(POS_WIDTH, TEX_WIDTH);
	localparam int JW = 6 * (POS_WIDTH + 1 - PS) + 4 * (TEX_WIDTH + 1 - TS);

	logic          fq_valid;
	logic          fq_stall;
	logic [JW-1:0] fq_data;
	logic          qb_valid;
	logic          qb_stall;
	logic [JW-1:0] qb_data;

	// corner counting and delta forming
	tbasis_front #(
		.POS_WIDTH (POS_WIDTH),
		.TEX_WIDTH (TEX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mesh_start (mesh_start),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.tex_u      (tex_u),
		.tex_v      (tex_v),
		.job_valid  (fq_valid),
		.job_stall  (fq_stall),
		.job_data   (fq_data)
	);

	// decouples vertex intake from the long back end sequence
	tbasis_queue #(
		.WIDTH (JW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_stall  (fq_stall),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_stall (qb_stall),
		.out_data  (qb_data)
	);

	// determinant sign, normalisation and cross product
	tbasis_back #(
		.POS_WIDTH (POS_WIDTH),
		.TEX_WIDTH (TEX_WIDTH),
		.OUT_WIDTH (OUT_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (qb_valid),
		.job_stall  (qb_stall),
		.job_data   (qb_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tangent_x  (tangent_x),
		.tangent_y  (tangent_y),
		.tangent_z  (tangent_z),
		.binormal_x (binormal_x),
		.binormal_y (binormal_y),
		.binormal_z (binormal_z),
		.normal_x   (normal_x),
		.normal_y   (normal_y),
		.normal_z   (normal_z),
		.degenerate (degenerate)
	);

endmodule
`default_nettype wire

/* src/tbasis_queue.sv */
// two entry request queue between the front and back parts
`default_nettype none
module tbasis_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem_q [0:1];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rp_q];
	assign push      = in_valid & ~in_stall;
	assign pop       = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

endmodule
`default_nettype wire

/* src/tbasis_front.sv */
// vertex front end: corner counting, held corners and edge / texture deltas
`default_nettype none
module tbasis_front import tbasis_pkg::*; #(
	parameter int POS_WIDTH = 24,
	parameter int TEX_WIDTH = 21,
	localparam int TS = tex_shift(TEX_WIDTH),
	localparam int PS = pos_shift(POS_WIDTH, TEX_WIDTH),
	localparam int EW = POS_WIDTH + 1 - PS,
	localparam int DW = TEX_WIDTH + 1 - TS,
	localparam int JW = 6 * EW + 4 * DW
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        mesh_start,
	input  wire logic signed [POS_WIDTH-1:0] pos_x,
	input  wire logic signed [POS_WIDTH-1:0] pos_y,
	input  wire logic signed [POS_WIDTH-1:0] pos_z,
	input  wire logic signed [TEX_WIDTH-1:0] tex_u,
	input  wire logic signed [TEX_WIDTH-1:0] tex_v,
	output logic                             job_valid,
	input  wire logic                        job_stall,
	output logic             [JW-1:0]        job_data
);

	localparam logic [POS_WIDTH:0] PMASK = (POS_WIDTH+1)'((64'd1 << PS) - 64'd1);
	localparam logic [TEX_WIDTH:0] TMASK = (TEX_WIDTH+1)'((64'd1 << TS) - 64'd1);

	logic        [1:0]           corner_q;
	logic signed [POS_WIDTH-1:0] p0_q [0:2];
	logic signed [POS_WIDTH-1:0] p1_q [0:2];
	logic signed [TEX_WIDTH-1:0] t0_q [0:1];
	logic signed [TEX_WIDTH-1:0] t1_q [0:1];
	logic        [1:0]           eff;
	logic                        third;
	logic                        accept;
	logic signed [POS_WIDTH-1:0] pin [0:2];
	logic signed [TEX_WIDTH-1:0] tin [0:1];
	logic signed [EW-1:0]        e1 [0:2];
	logic signed [EW-1:0]        e2 [0:2];
	logic signed [DW-1:0]        du1, dv1, du2, dv2;

	// difference truncated toward zero by the position shift
	function automatic logic signed [EW-1:0] pdelta(input logic signed [POS_WIDTH-1:0] a,
		input logic signed [POS_WIDTH-1:0] b);
		logic signed [POS_WIDTH:0] d;
		d = (POS_WIDTH+1)'(a) - (POS_WIDTH+1)'(b);
		if (d[POS_WIDTH]) d = d + $signed(PMASK);
		return EW'(d >>> PS);
	endfunction

	function automatic logic signed [DW-1:0] tdelta(input logic signed [TEX_WIDTH-1:0] a,
		input logic signed [TEX_WIDTH-1:0] b);
		logic signed [TEX_WIDTH:0] d;
		d = (TEX_WIDTH+1)'(a) - (TEX_WIDTH+1)'(b);
		if (d[TEX_WIDTH]) d = d + $signed(TMASK);
		return DW'(d >>> TS);
	endfunction

	assign pin[0] = pos_x;
	assign pin[1] = pos_y;
	assign pin[2] = pos_z;
	assign tin[0] = tex_u;
	assign tin[1] = tex_v;

	assign eff       = mesh_start ? 2'd0 : corner_q;
	assign third     = (eff == 2'd2);
	assign in_stall  = third & job_stall;
	assign job_valid = in_valid & third;
	assign accept    = in_valid & ~in_stall;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e1[i] = pdelta(p1_q[i], p0_q[i]);
			e2[i] = pdelta(pin[i], p0_q[i]);
		end
		du1 = tdelta(t1_q[0], t0_q[0]);
		dv1 = tdelta(t1_q[1], t0_q[1]);
		du2 = tdelta(tin[0], t0_q[0]);
		dv2 = tdelta(tin[1], t0_q[1]);
	end

	assign job_data = {e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], du1, dv1, du2, dv2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= 2'd0;
		end else if (accept) begin
			corner_q <= third ? 2'd0 : eff + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && eff == 2'd0) begin
			for (int i = 0; i < 3; i++) p0_q[i] <= pin[i];
			for (int i = 0; i < 2; i++) t0_q[i] <= tin[i];
		end
		if (accept && eff == 2'd1) begin
			for (int i = 0; i < 3; i++) p1_q[i] <= pin[i];
			for (int i = 0; i < 2; i++) t1_q[i] <= tin[i];
		end
	end

endmodule
`default_nettype wire

/* src/tbasis_back.sv */
// sequenced back end: shared multiplier, root and divider produce the unit vectors
`default_nettype none
module tbasis_back import tbasis_pkg::*; #(
	parameter int POS_WIDTH = 24,
	parameter int TEX_WIDTH = 21,
	parameter int OUT_WIDTH = 16,
	localparam int TS = tex_shift(TEX_WIDTH),
	localparam int PS = pos_shift(POS_WIDTH, TEX_WIDTH),
	localparam int EW = POS_WIDTH + 1 - PS,
	localparam int DW = TEX_WIDTH + 1 - TS,
	localparam int JW = 6 * EW + 4 * DW
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_valid,
	output logic                             job_stall,
	input  wire logic        [JW-1:0]        job_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic signed      [OUT_WIDTH-1:0] tangent_x,
	output logic signed      [OUT_WIDTH-1:0] tangent_y,
	output logic signed      [OUT_WIDTH-1:0] tangent_z,
	output logic signed      [OUT_WIDTH-1:0] binormal_x,
	output logic signed      [OUT_WIDTH-1:0] binormal_y,
	output logic signed      [OUT_WIDTH-1:0] binormal_z,
	output logic signed      [OUT_WIDTH-1:0] normal_x,
	output logic signed      [OUT_WIDTH-1:0] normal_y,
	output logic signed      [OUT_WIDTH-1:0] normal_z,
	output logic                             degenerate
);

	localparam int NW   = EW + DW + 1;
	localparam int DETW = 2 * DW + 1;
	localparam int MW   = imax(imax(EW, DW), imax(OUT_WIDTH, 32));
	localparam int PW   = 2 * MW;
	localparam int VW   = imax(imax(NW, 2 * OUT_WIDTH + 1), 32);
	localparam int F    = OUT_WIDTH - 1;
	localparam int QW   = 32 + F;
	localparam int DKW  = $clog2(QW);
	localparam logic [QW-1:0] LIM = QW'((64'd1 << F) - 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_MUL_END, ST_SIGN, ST_MAG, ST_SHIFT, ST_SQ, ST_SQ_END,
		ST_ROOT_INIT, ST_ROOT, ST_DIV_INIT, ST_DIV, ST_CROSS, ST_CROSS_END, ST_FINISH
	} state_t;

	typedef enum logic [1:0] {PH_SETUP, PH_SQ, PH_CROSS} phase_t;

	state_t               state_q;
	phase_t               ph_q;
	logic [3:0]           k_q;
	logic [3:0]           kd_q;
	logic                 pv_q;
	logic signed [EW-1:0] e1_q [0:2];
	logic signed [EW-1:0] e2_q [0:2];
	logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
	logic signed [DETW-1:0] det_q;
	logic signed [VW-1:0] vec_q [0:2][0:2];
	logic signed [OUT_WIDTH-1:0] res_q [0:2][0:2];
	logic signed [PW-1:0] prod_q;
	logic signed [PW-1:0] tmp_q;
	logic        [VW-1:0] a_q [0:2];
	logic        [VW-1:0] m_q;
	logic        [63:0]   sum_q;
	logic        [63:0]   x_q, r_q, bit_q;
	logic        [31:0]   rem_q;
	logic        [QW-1:0] q_q;
	logic        [DKW-1:0] dk_q;
	logic        [1:0]    ci_q;
	logic        [1:0]    vsel_q;
	logic                 degen_q;
	logic                 ovalid_q;
	logic signed [OUT_WIDTH-1:0] out_q [0:2][0:2];
	logic                 odegen_q;

	logic signed [MW-1:0] opa, opb;
	logic signed [PW-1:0] prod_c;
	logic signed [PW:0]   diff_c;
	logic        [3:0]    kk;
	logic        [1:0]    ki;
	logic        [2:0]    pj, pm;
	logic        [VW-1:0] mag_c [0:2];
	logic        [VW-1:0] mmax_c;
	logic        [63:0]   rt_c;
	logic        [QW-1:0] num_c;
	logic        [32:0]   rem2_c;
	logic                 ge_c;
	logic        [31:0]   remn_c;
	logic        [QW-1:0] qn_c;
	logic        [F-1:0]  qs_c;
	logic signed [OUT_WIDTH-1:0] comp_c;
	logic                 load_out;

	assign job_stall = (state_q != ST_IDLE);
	assign kk = k_q - 4'd2;
	assign ki = kk[3:2];

	// operand selection for the shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (state_q)
			ST_MUL: begin
				if (k_q == 4'd0) begin
					opa = MW'(du1_q); opb = MW'(dv2_q);
				end else if (k_q == 4'd1) begin
					opa = MW'(du2_q); opb = MW'(dv1_q);
				end else begin
					unique case (kk[1:0])
						2'd0: begin opa = MW'(dv2_q); opb = MW'(e1_q[ki]); end
						2'd1: begin opa = MW'(dv1_q); opb = MW'(e2_q[ki]); end
						2'd2: begin opa = MW'(du1_q); opb = MW'(e2_q[ki]); end
						default: begin opa = MW'(du2_q); opb = MW'(e1_q[ki]); end
					endcase
				end
			end
			ST_SQ: begin
				opa = $signed(MW'(a_q[k_q[1:0]][30:0]));
				opb = $signed(MW'(a_q[k_q[1:0]][30:0]));
			end
			ST_CROSS: begin
				unique case (k_q[2:0])
					3'd0: begin opa = MW'(res_q[0][1]); opb = MW'(res_q[1][2]); end
					3'd1: begin opa = MW'(res_q[0][2]); opb = MW'(res_q[1][1]); end
					3'd2: begin opa = MW'(res_q[0][2]); opb = MW'(res_q[1][0]); end
					3'd3: begin opa = MW'(res_q[0][0]); opb = MW'(res_q[1][2]); end
					3'd4: begin opa = MW'(res_q[0][0]); opb = MW'(res_q[1][1]); end
					default: begin opa = MW'(res_q[0][1]); opb = MW'(res_q[1][0]); end
				endcase
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign prod_c = opa * opb;
	assign diff_c = (PW+1)'(tmp_q) - (PW+1)'(prod_q);
	assign pj     = kd_q[3:1];
	assign pm     = pj - 3'd1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = vec_q[vsel_q][i][VW-1] ? VW'(-vec_q[vsel_q][i]) : VW'(vec_q[vsel_q][i]);
		end
		mmax_c = mag_c[0];
		if (mag_c[1] > mmax_c) mmax_c = mag_c[1];
		if (mag_c[2] > mmax_c) mmax_c = mag_c[2];
	end

	assign rt_c = r_q + bit_q;

	// one restoring division step per cycle
	assign num_c  = (QW'(a_q[ci_q][30:0]) << F) + QW'(r_q[31:1]);
	assign rem2_c = {rem_q, num_c[dk_q]};
	assign ge_c   = (rem2_c >= {1'b0, r_q[31:0]});
	assign remn_c = ge_c ? 32'(rem2_c - {1'b0, r_q[31:0]}) : rem2_c[31:0];
	assign qn_c   = {q_q[QW-2:0], ge_c};
	assign qs_c   = (qn_c > LIM) ? LIM[F-1:0] : qn_c[F-1:0];
	assign comp_c = vec_q[vsel_q][ci_q][VW-1] ? -$signed({1'b0, qs_c}) : $signed({1'b0, qs_c});

	assign load_out = (state_q == ST_FINISH) && (!ovalid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pv_q     <= 1'b0;
			ovalid_q <= 1'b0;
			k_q      <= '0;
			ph_q     <= PH_SETUP;
			odegen_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) out_q[i][j] <= '0;
		end else begin
			pv_q <= 1'b0;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_MUL;
						k_q     <= '0;
					end
				end
				ST_MUL: begin
					pv_q <= 1'b1;
					ph_q <= PH_SETUP;
					if (k_q == 4'd13) state_q <= ST_MUL_END;
					else k_q <= k_q + 4'd1;
				end
				ST_MUL_END: state_q <= ST_SIGN;
				ST_SIGN: begin
					if (det_q == '0) state_q <= ST_FINISH;
					else state_q <= ST_MAG;
				end
				ST_MAG: begin
					if (mmax_c == '0) state_q <= ST_FINISH;
					else state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (m_q[VW-1:31] == '0) begin
						state_q <= ST_SQ;
						k_q     <= '0;
					end
				end
				ST_SQ: begin
					pv_q <= 1'b1;
					ph_q <= PH_SQ;
					if (k_q == 4'd2) state_q <= ST_SQ_END;
					else k_q <= k_q + 4'd1;
				end
				ST_SQ_END:    state_q <= ST_ROOT_INIT;
				ST_ROOT_INIT: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (bit_q == 64'd1) state_q <= ST_DIV_INIT;
				end
				ST_DIV_INIT: state_q <= ST_DIV;
				ST_DIV: begin
					if (dk_q == '0 && ci_q == 2'd2) begin
						if (vsel_q == 2'd0) begin
							state_q <= ST_MAG;
						end else if (vsel_q == 2'd1) begin
							state_q <= ST_CROSS;
							k_q     <= '0;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_CROSS: begin
					pv_q <= 1'b1;
					ph_q <= PH_CROSS;
					if (k_q == 4'd5) state_q <= ST_CROSS_END;
					else k_q <= k_q + 4'd1;
				end
				ST_CROSS_END: state_q <= ST_MAG;
				ST_FINISH: begin
					if (load_out) begin
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
						odegen_q <= degen_q;
						for (int i = 0; i < 3; i++)
							for (int j = 0; j < 3; j++)
								out_q[i][j] <= degen_q ? '0 : res_q[i][j];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		kd_q   <= k_q;
		if (pv_q) begin
			unique case (ph_q)
				PH_SETUP: begin
					if (!kd_q[0]) tmp_q <= prod_q;
					else if (pj == 3'd0) det_q <= DETW'(diff_c);
					else vec_q[{1'b0, pm[0]}][pm[2:1]] <= VW'(diff_c);
				end
				PH_SQ: sum_q <= sum_q + prod_q[63:0];
				PH_CROSS: begin
					if (!kd_q[0]) tmp_q <= prod_q;
					else vec_q[2][pj[1:0]] <= VW'(diff_c);
				end
				default: tmp_q <= prod_q;
			endcase
		end
		unique case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					{e1_q[0], e1_q[1], e1_q[2], e2_q[0], e2_q[1], e2_q[2],
						du1_q, dv1_q, du2_q, dv2_q} <= job_data;
					degen_q <= 1'b0;
				end
			end
			ST_SIGN: begin
				vsel_q <= 2'd0;
				if (det_q == '0) degen_q <= 1'b1;
				else if (det_q[DETW-1]) begin
					for (int i = 0; i < 2; i++)
						for (int j = 0; j < 3; j++) vec_q[i][j] <= -vec_q[i][j];
				end
			end
			ST_MAG: begin
				for (int i = 0; i < 3; i++) a_q[i] <= mag_c[i];
				m_q <= mmax_c;
				if (mmax_c == '0) degen_q <= 1'b1;
			end
			ST_SHIFT: begin
				sum_q <= '0;
				if (m_q[VW-1:31] != '0) begin
					for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
					m_q <= m_q >> 1;
				end
			end
			ST_ROOT_INIT: begin
				x_q   <= sum_q;
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			ST_ROOT: begin
				if (x_q >= rt_c) begin
					x_q <= x_q - rt_c;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_DIV_INIT: begin
				ci_q  <= 2'd0;
				rem_q <= '0;
				q_q   <= '0;
				dk_q  <= DKW'(QW - 1);
			end
			ST_DIV: begin
				if (dk_q == '0) begin
					res_q[vsel_q][ci_q] <= comp_c;
					rem_q <= '0;
					q_q   <= '0;
					dk_q  <= DKW'(QW - 1);
					if (ci_q == 2'd2) vsel_q <= vsel_q + 2'd1;
					else ci_q <= ci_q + 2'd1;
				end else begin
					rem_q <= remn_c;
					q_q   <= qn_c;
					dk_q  <= dk_q - DKW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = ovalid_q;
	assign degenerate = odegen_q;
	assign tangent_x  = out_q[0][0];
	assign tangent_y  = out_q[0][1];
	assign tangent_z  = out_q[0][2];
	assign binormal_x = out_q[1][0];
	assign binormal_y = out_q[1][1];
	assign binormal_z = out_q[1][2];
	assign normal_x   = out_q[2][0];
	assign normal_y   = out_q[2][1];
	assign normal_z   = out_q[2][2];

endmodule
`default_nettype wire
